[hdl/lcg_pkg.sv]
// Shared constants and types for the linear chirp generator.
`timescale 1ns / 1ps

package lcg_pkg;

    // Quarter-wave table entry width, unsigned, full scale 65536.
    localparam int ENTRY_W = 16;

    // pi/2 in Q30, seeds the table series.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY  = 3'd0,
        CFG_SAMPLE_COUNT = 3'd1,
        CFG_FIRST_STEP   = 3'd2,
        CFG_STEP_GROWTH  = 3'd3,
        CFG_AMPLITUDE    = 3'd4
    } t_cfg_reg;

endpackage

[hdl/linear_chirp_generator_top.sv]
// Linear chirp generator: delay counter, quadratic phase recursion, sine table and scaler.
// A tick word passes the stage-1, table-read and output registers before its result shows.
// Throughput: one tick word per cycle unless stalled; the recursion is two 48-bit adds.
// Pipeline: phase/address stage, table read stage, amplitude multiply and round stage.
// Reset (i_rst_n low, synchronous): waiting mode, counters and phase cleared,
// registers back to their defaults, pipeline emptied.
`timescale 1ns / 1ps

module linear_chirp_generator_top
    import lcg_pkg::*;
#(
    parameter int PHASE_BITS       = 48,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // tick channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_tick,
    // sample channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_sweeping,
    output logic                          o_last
);

    localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W  = 30 + DEPTH_W;
    localparam int CMP_W   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam logic [CMP_W-1:0] LIM = CMP_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    typedef enum logic [1:0] {
        MODE_WAITING,
        MODE_SWEEPING,
        MODE_DONE
    } t_mode;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [23:0]           r_start_delay;
    logic [23:0]           r_sample_count;
    logic [PHASE_BITS-1:0] r_first_step;
    logic [PHASE_BITS-1:0] r_step_growth;
    logic [14:0]           r_amplitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay  <= 24'd4995;
            r_sample_count <= 24'd29970;
            r_first_step   <= PHASE_BITS'(48'd2826851000);
            r_step_growth  <= PHASE_BITS'(48'd18709000);
            r_amplitude    <= 15'd10240;
        end else if (i_cfg_we) begin
            // indexes past the register list are dropped
            unique case (i_cfg_idx)
                CFG_START_DELAY:  r_start_delay  <= i_cfg_data[23:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[23:0];
                CFG_FIRST_STEP:   r_first_step   <= PHASE_BITS'(i_cfg_data);
                CFG_STEP_GROWTH:  r_step_growth  <= PHASE_BITS'(i_cfg_data);
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: each stage advances when the one after it
    // is empty or advancing, so bubbles are squeezed out and a new tick
    // word is taken while a finished sample waits downstream.
    // ---------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic acc;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign acc     = i_valid && en1;

    // ---------------------------------------------------------------
    // Stage 1: sweep control, phase recursion, table address
    // ---------------------------------------------------------------
    t_mode                 r_mode;
    logic [23:0]           r_delay_left;
    logic [23:0]           r_sample_index;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_phase_step;

    t_mode                 n_mode;
    logic [23:0]           n_delay_left;
    logic [23:0]           n_sample_index;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] n_phase_step;

    logic                  start;
    logic [PHASE_BITS-1:0] eff_phase;
    logic [PHASE_BITS-1:0] eff_step;
    logic [23:0]           eff_idx;
    logic                  is_last;
    logic                  emit;
    logic                  emit_sweep;
    logic                  emit_last;

    logic [PHASE_BITS+31:0] phase_ext;
    logic [31:0]            top;
    logic [PROD_W-1:0]      addr_prod;
    logic [DEPTH_W-1:0]     addr_raw;
    logic [ADDR_W-1:0]      addr_fold;
    logic [ADDR_W-1:0]      n_addr;

    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s1_neg;
    logic                  r_s1_sweep;
    logic                  r_s1_last;

    // Leaving the delay latches a fresh phase and the first step; the
    // first sweep sample goes out on that same tick.
    assign start     = (r_mode == MODE_WAITING) && !(r_delay_left < r_start_delay);
    assign eff_phase = start ? '0 : r_phase;
    assign eff_step  = start ? r_first_step : r_phase_step;
    assign eff_idx   = start ? 24'd0 : r_sample_index;
    assign is_last   = ({1'b0, eff_idx} + 25'd1) == {1'b0, r_sample_count};

    always_comb begin
        n_mode         = r_mode;
        n_delay_left   = r_delay_left;
        n_sample_index = r_sample_index;
        n_phase        = r_phase;
        n_phase_step   = r_phase_step;
        emit           = 1'b0;
        emit_sweep     = 1'b0;
        emit_last      = 1'b0;
        if (i_tick) begin
            if ((r_mode == MODE_WAITING) && !start) begin
                // delay word: zero sample
                n_delay_left = r_delay_left + 24'd1;
                emit         = 1'b1;
            end else if ((r_mode == MODE_SWEEPING) || start) begin
                n_mode = MODE_SWEEPING;
                if (eff_idx >= r_sample_count) begin
                    // count exhausted (or lowered under the index): fall silent
                    n_mode = MODE_DONE;
                end else begin
                    emit           = 1'b1;
                    emit_sweep     = 1'b1;
                    emit_last      = is_last;
                    n_phase        = eff_phase + eff_step;
                    n_phase_step   = eff_step + r_step_growth;
                    n_sample_index = eff_idx + 24'd1;
                    if (is_last) begin
                        n_mode = MODE_DONE;
                    end
                end
            end
        end
    end

    // Top 32 phase bits (zero padded for short phases): quadrant in 31:30,
    // fraction in 29:0 scaled to the table depth, mirrored in odd quadrants.
    assign phase_ext = {eff_phase, 32'd0};
    assign top       = phase_ext[PHASE_BITS+31 -: 32];
    assign addr_prod = PROD_W'(top[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign addr_raw  = addr_prod[PROD_W-1:30];
    assign addr_fold = addr_raw[ADDR_W-1:0];
    assign n_addr    = top[30] ? (ADDR_W'(SINE_TABLE_DEPTH - 1) - addr_fold) : addr_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_WAITING;
            r_delay_left   <= '0;
            r_sample_index <= '0;
            r_phase        <= '0;
            r_phase_step   <= '0;
            r_v1           <= 1'b0;
        end else begin
            if (acc) begin
                r_mode         <= n_mode;
                r_delay_left   <= n_delay_left;
                r_sample_index <= n_sample_index;
                r_phase        <= n_phase;
                r_phase_step   <= n_phase_step;
            end
            if (en1) begin
                r_v1 <= acc && emit;
            end
        end
        if (en1) begin
            r_s1_addr  <= n_addr;
            r_s1_neg   <= top[31];
            r_s1_sweep <= emit_sweep;
            r_s1_last  <= emit_last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: table read
    // ---------------------------------------------------------------
    logic [ENTRY_W-1:0] rom_entry;
    logic               r_s2_neg;
    logic               r_s2_sweep;
    logic               r_s2_last;

    lcg_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (en2),
        .i_addr  (r_s1_addr),
        .o_entry (rom_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r_s2_neg   <= r_s1_neg;
            r_s2_sweep <= r_s1_sweep;
            r_s2_last  <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: scale by amplitude, round, sign, saturate
    // ---------------------------------------------------------------
    logic [30:0]                   amp_prod;
    logic [31:0]                   amp_rnd;
    logic [CMP_W-1:0]              mag;
    logic [CMP_W-1:0]              mag_sat;
    logic signed [SAMPLE_BITS-1:0] n_sample;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_sweeping;
    logic                          r_last;

    assign amp_prod = 31'(r_amplitude) * 31'(rom_entry);
    assign amp_rnd  = 32'(amp_prod) + 32'h0000_8000;
    assign mag      = CMP_W'(amp_rnd[31:16]);
    assign mag_sat  = (mag > LIM) ? LIM : mag;

    always_comb begin
        if (!r_s2_sweep) begin
            n_sample = '0;
        end else if (r_s2_neg) begin
            n_sample = -SAMPLE_BITS'(mag_sat);
        end else begin
            n_sample = SAMPLE_BITS'(mag_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r_sample   <= n_sample;
            r_sweeping <= r_s2_sweep;
            r_last     <= r_s2_last;
        end
    end

    assign o_valid    = r_v3;
    assign o_sample   = r_sample;
    assign o_sweeping = r_sweeping;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    // delay words carry a zero sample and never the last flag
    a_delay_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sweeping) |-> ((o_sample == '0) && !o_last))
        else $error("delay word with nonzero sample or last flag");

    // the last flag only rides on sweep words
    a_last_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_sweeping)
        else $error("last flag outside the sweep");

    // issuing the final sweep word retires the sweep
    a_last_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit_last) |=> (r_mode == MODE_DONE))
        else $error("sweep not retired after its last word");

    // the most negative code is never produced
    a_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("sample outside the symmetric range");
`endif

endmodule

[hdl/lcg_sine_rom.sv]
// Quarter-wave sine table with a registered read port.
`timescale 1ns / 1ps

module lcg_sine_rom
    import lcg_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [ENTRY_W-1:0]         o_entry
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam longint unsigned TWO_DEPTH = 2 * DEPTH;

    // Entry k = round(65536 * sin(pi/2 * (k + 0.5) / DEPTH)), Q30 Taylor series.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'(2 * k + 1) * HALF_PI_Q30) / TWO_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd8192) >> 14;
        if (v > 64'd65535) begin
            v = 64'd65535;
        end
        return v[ENTRY_W-1:0];
    endfunction

    logic [ENTRY_W-1:0] rom [DEPTH];
    logic [ENTRY_W-1:0] r_entry;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [ENTRY_W-1:0] VAL = sine_entry(k);
        assign rom[k] = VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= rom[i_addr[ADDR_W-1:0]];
        end
    end

    assign o_entry = r_entry;

endmodule

[tb/sv/chirp_sample_checker.sv]
// Chirp sample checker: predicts each sample word from the tick words and compares.
`timescale 1ns / 1ps

module chirp_sample_checker
    import lcg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_stall,
    input  logic                  i_tick,
    input  logic                  i_smp_valid,
    input  logic                  i_smp_stall,
    input  logic signed [15:0]    i_sample,
    input  logic                  i_sweeping,
    input  logic                  i_last,
    output int                    o_failures,
    output int                    o_pending
);

    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        GEN_WAITING,
        GEN_SWEEPING,
        GEN_DONE
    } t_gen_mode;

    typedef struct packed {
        logic signed [15:0] value;
        logic               sweeping;
        logic               last;
    } t_chirp_word;

    logic [15:0] quarter_wave [0:1023];

    logic [23:0] delay_cfg;
    logic [23:0] length_cfg;
    logic [47:0] step_init_cfg;
    logic [47:0] step_inc_cfg;
    logic [14:0] peak_cfg;

    t_gen_mode   gen_mode;
    logic [23:0] delay_done;
    logic [23:0] sweep_idx;
    logic [47:0] acc_phase;
    logic [47:0] acc_step;

    t_chirp_word expected_words [$];
    int          failures = 0;

    // Quarter sine in Q30 by an eleven-term series, rounded to 16 bits.
    initial begin : build_quarter_wave
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned div;
        longint unsigned v;
        for (int k = 0; k < 1024; k++) begin
            x    = (longint'(2 * k + 1) * QUARTER_TURN_Q30) / 64'd2048;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 10; n++) begin
                div  = longint'((2 * n) * (2 * n + 1));
                term = ((term * x2) >> 30) / div;
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            v = (acc + 64'd8192) >> 14;
            if (v > 64'd65535) begin
                v = 64'd65535;
            end
            quarter_wave[k] = v[15:0];
        end
    end

    function automatic logic signed [15:0] chirp_value(input logic [47:0] ph);
        logic [31:0] top32;
        logic [9:0]  addr;
        logic [31:0] prod;
        logic [15:0] mag;
        top32 = ph[47:16];
        addr  = top32[29:20];
        if (top32[30]) begin
            addr = 10'd1023 - addr;
        end
        prod = {17'd0, peak_cfg} * {16'd0, quarter_wave[addr]} + 32'd32768;
        mag  = prod[31:16];
        return top32[31] ? -$signed(mag) : $signed(mag);
    endfunction

    task automatic take_tick();
        t_chirp_word w;
        logic        last_word;
        if (gen_mode == GEN_WAITING) begin
            if (delay_done < delay_cfg) begin
                delay_done++;
                w = '0;
                expected_words = {expected_words, w};
                return;
            end
            gen_mode  = GEN_SWEEPING;
            sweep_idx = '0;
            acc_phase = '0;
            acc_step  = step_init_cfg;
        end
        if (gen_mode != GEN_SWEEPING) begin
            return;
        end
        if (sweep_idx >= length_cfg) begin
            gen_mode = GEN_DONE;
            return;
        end
        last_word  = ({1'b0, sweep_idx} + 25'd1 == {1'b0, length_cfg});
        w.value    = chirp_value(acc_phase);
        w.sweeping = 1'b1;
        w.last     = last_word;
        expected_words = {expected_words, w};
        acc_phase = acc_phase + acc_step;
        acc_step  = acc_step + step_inc_cfg;
        sweep_idx = sweep_idx + 24'd1;
        if (last_word) begin
            gen_mode = GEN_DONE;
        end
    endtask

    task automatic check_word();
        t_chirp_word want;
        if (expected_words.size() == 0) begin
            $error("sample word with nothing expected: sample %0d", i_sample);
            failures++;
            return;
        end
        want = expected_words.pop_front();
        if (i_sample !== want.value) begin
            $error("sample: expected %0d, got %0d", $signed(want.value), i_sample);
            failures++;
        end
        if (i_sweeping !== want.sweeping) begin
            $error("sweeping: expected %0b, got %0b", want.sweeping, i_sweeping);
            failures++;
        end
        if (i_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, i_last);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delay_cfg     = 24'd4995;
            length_cfg    = 24'd29970;
            step_init_cfg = 48'd2826851000;
            step_inc_cfg  = 48'd18709000;
            peak_cfg      = 15'd10240;
            gen_mode      = GEN_WAITING;
            delay_done    = '0;
            sweep_idx     = '0;
            acc_phase     = '0;
            acc_step      = '0;
            expected_words.delete();
        end else begin
            if (i_smp_valid && !i_smp_stall) begin
                check_word();
            end
            if (i_tick_valid && !i_tick_stall && i_tick) begin
                take_tick();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_DELAY:  delay_cfg     = i_cfg_data[23:0];
                    CFG_SAMPLE_COUNT: length_cfg    = i_cfg_data[23:0];
                    CFG_FIRST_STEP:   step_init_cfg = i_cfg_data[47:0];
                    CFG_STEP_GROWTH:  step_inc_cfg  = i_cfg_data[47:0];
                    CFG_AMPLITUDE:    peak_cfg      = i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        o_pending  <= expected_words.size();
        o_failures <= failures;
    end

endmodule

[tb/sv/testbench.sv]
// Top of the chirp generator testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import lcg_pkg::*;

    // Cycles with no word moved on any port before the run is declared hung.
    localparam int IDLE_LIMIT   = 1000;
    // Extra cycles after the last sample word: covers the three-stage pipeline
    // plus words that leave no result behind them.
    localparam int DRAIN_CYCLES = 8;
    // Tick words with tick high in the random part.
    localparam int RANDOM_WORDS = 700;
    // Delay words given before the sweep starts in the directed part.
    localparam int DELAY_WORDS  = 3;
    // An index past the register list; the block drops writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  tick_valid   = 1'b0;
    logic                  tick_stall;
    logic                  tick         = 1'b0;
    logic                  smp_valid;
    logic                  smp_stall    = 1'b0;
    logic signed [15:0]    smp_value;
    logic                  smp_sweeping;
    logic                  smp_last;

    int failures;
    int pending;

    // Sender burst state and count of tick-high words accepted.
    int burst_left  = 0;
    int ones_sent   = 0;
    int idle_cycles = 0;

    // Receiver stall pattern state.
    logic [1:0] stall_style = 2'd0;
    int         style_left  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_chirp_generator_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (tick_valid),
        .o_stall    (tick_stall),
        .i_tick     (tick),
        .o_valid    (smp_valid),
        .i_stall    (smp_stall),
        .o_sample   (smp_value),
        .o_sweeping (smp_sweeping),
        .o_last     (smp_last)
    );

    chirp_sample_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_tick_valid (tick_valid),
        .i_tick_stall (tick_stall),
        .i_tick       (tick),
        .i_smp_valid  (smp_valid),
        .i_smp_stall  (smp_stall),
        .i_sample     (smp_value),
        .i_sweeping   (smp_sweeping),
        .i_last       (smp_last),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    // Stall the sample channel in styles that are picked at random and changed again and again:
    // never, now and then, most of the time, and a fixed periodic pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            smp_stall   <= 1'b0;
            stall_style <= 2'd0;
            style_left  <= 0;
        end else begin
            if (style_left == 0) begin
                stall_style <= 2'($urandom_range(0, 3));
                style_left  <= $urandom_range(20, 150);
            end else begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                2'd0: smp_stall <= 1'b0;
                2'd1: smp_stall <= ($urandom_range(0, 3) == 0);
                2'd2: smp_stall <= ($urandom_range(0, 3) != 0);
                default: smp_stall <= (style_left % 7 < 3);
            endcase
        end
    end

    // Count cycles in which no word moves; end the run if it hangs.
    always @(posedge clk) begin
        if ((tick_valid && !tick_stall) || (smp_valid && !smp_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one tick word and hold it until accepted. Open a random gap
    // first whenever the current burst has run out; a third of the bursts
    // follow the previous one with no gap at all.
    task automatic send_word(input logic t);
        int gap;
        cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
        burst_left--;
        if (t) begin
            ones_sent++;
        end
    endtask

    // Drop valid and hold until every expected sample word has come, then
    // let the pipeline empty out before touching the registers.
    task automatic wait_drained();
        tick_valid <= 1'b0;
        cfg_we     <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the enable stays up so that writes can follow
    // back to back, and the next word or drain lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Write a random register with random data. Keep the sample count high
    // so the sweep outlives the random part, and hit the extremes of the
    // growth and amplitude now and then.
    task automatic random_write();
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        idx  = CFG_IDX_W'($urandom_range(0, 7));
        data = {16'($urandom), 32'($urandom)};
        case (idx)
            CFG_SAMPLE_COUNT: data[23:20] = 4'hF;
            CFG_STEP_GROWTH, CFG_AMPLITUDE: begin
                case ($urandom_range(0, 3))
                    0: data = '0;
                    1: data = '1;
                    default: ;
                endcase
            end
            default: ;
        endcase
        write_reg(idx, data);
    endtask

    initial begin : stimulus
        int          random_sent;
        int          phase_len;
        logic [23:0] end_count;
        random_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Longest delay and sweep, full-scale first step and a quarter-turn
        // growth so the phase walks through every quadrant at peak amplitude.
        write_reg(CFG_START_DELAY, 48'hFF_FFFF);
        write_reg(CFG_SAMPLE_COUNT, 48'hFF_FFFF);
        write_reg(CFG_FIRST_STEP, '1);
        write_reg(CFG_STEP_GROWTH, 48'h4000_0000_0000);
        write_reg(CFG_AMPLITUDE, 48'h7FFF);
        write_reg(CFG_NO_REG, '1);

        // Delay words, with tick-low words mixed in that must leave no trace.
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);

        // Cut the delay to zero mid-wait: the next tick starts the sweep.
        wait_drained();
        write_reg(CFG_START_DELAY, '0);
        repeat (6) send_word(1'b1);

        // Silence the output and push the growth to its top.
        wait_drained();
        write_reg(CFG_AMPLITUDE, '0);
        write_reg(CFG_STEP_GROWTH, '1);
        repeat (5) send_word(1'b1);

        // Smallest nonzero amplitude, growth frozen.
        wait_drained();
        write_reg(CFG_AMPLITUDE, 48'd1);
        write_reg(CFG_STEP_GROWTH, '0);
        repeat (5) send_word(1'b1);

        // Random phases: settle, rewrite a few registers, then a run of words.
        while (random_sent < RANDOM_WORDS) begin
            wait_drained();
            repeat ($urandom_range(1, 3)) random_write();
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) begin
                send_word($urandom_range(0, 9) != 0);
                if (tick) begin
                    random_sent++;
                end
            end
        end

        // End the sweep: mostly on a flagged final sample, otherwise by
        // dropping the count to or below the samples already given, or to zero.
        wait_drained();
        case ($urandom_range(0, 3))
            0, 1: end_count = 24'(ones_sent - DELAY_WORDS + $urandom_range(1, 6));
            2: end_count = 24'($urandom_range(0, ones_sent - DELAY_WORDS));
            default: end_count = '0;
        endcase
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(end_count));
        repeat (25) send_word($urandom_range(0, 3) != 0);

        wait_drained();
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
